FILE: rtl/dddc_pkg.sv
// dddc_pkg: shared types and constants of the dawn/dusk door controller
// no dependencies; imported by every module of the block but dddc_ram

package dddc_pkg;

	// field widths
	localparam int SAMPLE_W   = 10;
	localparam int CNT_W      = 16;
	localparam int LED_W      = 8;
	localparam int DEB_W      = 8;
	localparam int DOOR_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// average is ring sum shifted right by this, whatever the ring depth
	localparam int AVG_SHIFT = 3;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};
	localparam logic [LED_W-1:0]    LED_ALL    = {LED_W{1'b1}};
	localparam int                  LED_COUNT_W = $clog2(LED_W);

	// door position codes
	localparam logic [DOOR_W-1:0] DOOR_UNKNOWN = 2'd0;
	localparam logic [DOOR_W-1:0] DOOR_CLOSED  = 2'd1;
	localparam logic [DOOR_W-1:0] DOOR_OPEN    = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RISE_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SET_THRESHOLD  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TICKS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LED_STEP       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 3'd4;

	// register reset values
	localparam logic [SAMPLE_W-1:0] RISE_THRESHOLD_RST = 10'd650;
	localparam logic [SAMPLE_W-1:0] SET_THRESHOLD_RST  = 10'd500;
	localparam logic [CNT_W-1:0]    DWELL_TICKS_RST    = 16'd12000;
	localparam logic [CNT_W-1:0]    LED_STEP_RST       = 16'd1500;
	localparam logic [DEB_W-1:0]    DEBOUNCE_TICKS_RST = 8'd10;

	typedef struct packed {
		logic [SAMPLE_W-1:0] light_sample;
		logic                button_pressed;
	} in_item_t;

	typedef struct packed {
		logic                open_cmd;
		logic                close_cmd;
		logic                motor_on_req;
		logic                motor_off_req;
		logic [DOOR_W-1:0]   door_state;
		logic [SAMPLE_W-1:0] average_level;
		logic [LED_W-1:0]    led_pattern;
	} out_item_t;

	// status of the shared divider
	typedef struct packed {
		logic             busy;
		logic [CNT_W-1:0] quotient;
	} div_status_t;

endpackage

FILE: rtl/dawn_dusk_door_controller_top.sv
// dawn_dusk_door_controller_top: sequencer, ring, dwell filter and button logic
// depends on dddc_pkg, dddc_ram and dddc_div

// Each input transaction carries one light sample and the button level; each one gives exactly
// one result transaction. After the accepting edge (the old ring entry is read at acceptance)
// the sequencer steps through the running-sum update and ring write, then the dwell counters
// and door position, which also starts the shared restoring divider that turns the dwell count
// into the LED bar length, then a wait on the divider (16 quotient bits, one per cycle) until
// its idle flag is seen, and last the button logic and the output register load, which waits
// while a held result is stalled. in_stall is high for the whole of that time, so no new item
// is taken before the last is through; the output register is separate, so a new item is
// accepted while the previous result still waits to be taken, and only the final load waits
// for it. The sample ring is a RING_DEPTH entry ram with one valid flop per entry, so reset
// needs no clearing pass and an unwritten entry counts as zero. cfg_ready is always high;
// registers are meant to be written only while the block is idle.

module dawn_dusk_door_controller_top
	import dddc_pkg::*;
#(
	parameter int RING_DEPTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam int SUM_W = SAMPLE_W + $clog2(RING_DEPTH);

	// sequencer codes
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SUM   = 3'd1;
	localparam logic [2:0] ST_DWELL = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_PUT   = 3'd4;

	logic [2:0] state_q;

	// configuration registers
	logic [SAMPLE_W-1:0] rise_thr_q;
	logic [SAMPLE_W-1:0] set_thr_q;
	logic [CNT_W-1:0]    dwell_q;
	logic [CNT_W-1:0]    led_step_q;
	logic [DEB_W-1:0]    debounce_q;

	// block state
	logic [PTR_W-1:0]      ptr_q;
	logic [RING_DEPTH-1:0] ring_valid_q;
	logic [SUM_W-1:0]      sum_q;
	logic [CNT_W-1:0]      bright_q;
	logic [CNT_W-1:0]      dark_q;
	logic [DOOR_W-1:0]     door_q;
	logic [DEB_W-1:0]      press_q;
	logic                  manual_q;

	// per-item working registers
	logic [SAMPLE_W-1:0] sample_q;
	logic                pressed_q;
	logic                open_q;
	logic                close_q;
	logic [SAMPLE_W-1:0] avg_q;

	// output register
	logic      out_valid_q;
	out_item_t out_data_q;

	logic                in_accept;
	logic [SAMPLE_W-1:0] ring_rdata;
	logic [SAMPLE_W-1:0] old_sample;
	logic [SUM_W-1:0]    sum_shift;
	logic [SAMPLE_W-1:0] avg;
	logic                put_go;

	// dwell evaluation
	logic             bright_fire;
	logic [CNT_W-1:0] bright_next;
	logic             dark_fire;
	logic [CNT_W-1:0] dark_next;
	logic [DOOR_W-1:0] door_next;
	logic [CNT_W-1:0] bar_count;

	// result assembly
	logic [LED_W-1:0]  bar_leds;
	logic [LED_W-1:0]  leds;
	logic              mon;
	logic              moff;
	logic [DOOR_W-1:0] door_final;
	logic [DEB_W-1:0]  press_next;
	logic              manual_next;

	div_status_t div_st;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// result may be loaded once the previous one has gone or is going now
	assign put_go = (state_q == ST_PUT) && (!out_valid_q || !out_stall);

	//--------------------------------------------------------------------------------
	// sample ring: old entry read at accept, new one written in the sum step
	//--------------------------------------------------------------------------------
	dddc_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (state_q == ST_SUM),
		.waddr (ptr_q),
		.wdata (sample_q),
		.re    (in_accept),
		.raddr (ptr_q),
		.rdata (ring_rdata)
	);

	// never-written entries read as zero through their clear valid flag
	assign old_sample = ring_valid_q[ptr_q] ? ring_rdata : '0;

	// average from the running sum, saturated for deep rings
	assign sum_shift = sum_q >> AVG_SHIFT;
	assign avg = (sum_shift > SUM_W'(SAMPLE_MAX)) ? SAMPLE_MAX : sum_shift[SAMPLE_W-1:0];

	//--------------------------------------------------------------------------------
	// dwell filter: rising test first, setting test only when it did not fire
	//--------------------------------------------------------------------------------
	always_comb begin
		bright_fire = 1'b0;
		bright_next = '0;
		dark_fire   = 1'b0;
		dark_next   = '0;
		door_next   = door_q;
		if ((door_q != DOOR_OPEN) && (avg_q > rise_thr_q)) begin
			if (bright_q < dwell_q) begin
				bright_next = bright_q + CNT_W'(1);
			end else begin
				bright_fire = 1'b1;
				bright_next = bright_q;
			end
		end
		if (bright_fire) begin
			// dark counter left alone in a sunrise tick
			dark_next = dark_q;
			door_next = DOOR_OPEN;
		end else if ((door_q != DOOR_CLOSED) && (avg_q < set_thr_q)) begin
			if (dark_q < dwell_q) begin
				dark_next = dark_q + CNT_W'(1);
			end else begin
				dark_fire = 1'b1;
				dark_next = dark_q;
				door_next = DOOR_CLOSED;
			end
		end
		bar_count = (dark_next > bright_next) ? dark_next : bright_next;
	end

	// shared divider: dwell count over led step gives the bar length
	dddc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_DWELL),
		.dividend (bar_count),
		.divisor  (led_step_q),
		.status   (div_st)
	);

	//--------------------------------------------------------------------------------
	// bar pattern and button override
	//--------------------------------------------------------------------------------
	always_comb begin
		if ((led_step_q == '0) || (|div_st.quotient[CNT_W-1:LED_COUNT_W])) begin
			bar_leds = LED_ALL;
		end else begin
			bar_leds = ~(LED_ALL << div_st.quotient[LED_COUNT_W-1:0]);
		end
		leds        = bar_leds;
		mon         = open_q || close_q;
		moff        = 1'b0;
		door_final  = door_q;
		press_next  = press_q;
		manual_next = manual_q;
		if (pressed_q) begin
			if (press_q < debounce_q) begin
				press_next = press_q + DEB_W'(1);
			end else begin
				// manual hold: motor on, all leds, position no longer known
				mon         = 1'b1;
				leds        = LED_ALL;
				manual_next = 1'b1;
				door_final  = DOOR_UNKNOWN;
			end
		end else begin
			press_next = '0;
			if (manual_q) begin
				manual_next = 1'b0;
				leds        = '0;
				moff        = 1'b1;
			end
		end
	end

	//--------------------------------------------------------------------------------
	// sequencer and control state
	//--------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ptr_q        <= '0;
			ring_valid_q <= '0;
			sum_q        <= '0;
			bright_q     <= '0;
			dark_q       <= '0;
			door_q       <= DOOR_UNKNOWN;
			press_q      <= '0;
			manual_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					sum_q <= sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
					ring_valid_q[ptr_q] <= 1'b1;
					if (ptr_q == PTR_W'(RING_DEPTH - 1)) begin
						ptr_q <= '0;
					end else begin
						ptr_q <= ptr_q + PTR_W'(1);
					end
					state_q <= ST_DWELL;
				end
				ST_DWELL: begin
					bright_q <= bright_next;
					dark_q   <= dark_next;
					door_q   <= door_next;
					state_q  <= ST_DIV;
				end
				ST_DIV: begin
					if (!div_st.busy) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (put_go) begin
						door_q   <= door_final;
						press_q  <= press_next;
						manual_q <= manual_next;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (put_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			sample_q  <= in_data.light_sample;
			pressed_q <= in_data.button_pressed;
		end
		if (state_q == ST_SUM) begin
			avg_q <= (((sum_q - SUM_W'(old_sample) + SUM_W'(sample_q)) >> AVG_SHIFT)
				> SUM_W'(SAMPLE_MAX)) ? SAMPLE_MAX
				: SAMPLE_W'((sum_q - SUM_W'(old_sample) + SUM_W'(sample_q)) >> AVG_SHIFT);
		end
		if (state_q == ST_DWELL) begin
			open_q  <= bright_fire;
			close_q <= dark_fire;
		end
		if (put_go) begin
			out_data_q.open_cmd      <= open_q;
			out_data_q.close_cmd     <= close_q;
			out_data_q.motor_on_req  <= mon;
			out_data_q.motor_off_req <= moff;
			out_data_q.door_state    <= door_final;
			out_data_q.average_level <= avg;
			out_data_q.led_pattern   <= leds;
		end
	end

	// configuration registers, writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_thr_q <= RISE_THRESHOLD_RST;
			set_thr_q  <= SET_THRESHOLD_RST;
			dwell_q    <= DWELL_TICKS_RST;
			led_step_q <= LED_STEP_RST;
			debounce_q <= DEBOUNCE_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RISE_THRESHOLD: rise_thr_q <= cfg_data[SAMPLE_W-1:0];
				CFG_SET_THRESHOLD:  set_thr_q  <= cfg_data[SAMPLE_W-1:0];
				CFG_DWELL_TICKS:    dwell_q    <= cfg_data[CNT_W-1:0];
				CFG_LED_STEP:       led_step_q <= cfg_data[CNT_W-1:0];
				CFG_DEBOUNCE_TICKS: debounce_q <= cfg_data[DEB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	//--------------------------------------------------------------------------------
	// assertions
	//--------------------------------------------------------------------------------

	// an accepted item keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> in_stall)
		else $error("block not busy after accepting an item");

	// the divider only runs while the sequencer waits for it
	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.busy |-> (state_q == ST_DIV))
		else $error("divider busy outside its step");

	// never both commands in one result
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.open_cmd && out_data.close_cmd))
		else $error("open and close commanded together");

	// a command always asks for motor power
	a_cmd_motor: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.open_cmd || out_data.close_cmd)) |-> out_data.motor_on_req)
		else $error("command without motor request");

	// a result is loaded only from the last step
	a_load_from_put: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !$past(out_valid)) |-> ($past(state_q) == ST_PUT))
		else $error("result loaded outside the final step");

endmodule

FILE: rtl/dddc_ram.sv
// dddc_ram: generic single write port ram with one registered read port
// no dependencies

module dddc_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/dddc_div.sv
// dddc_div: iterative restoring divider, one quotient bit per cycle
// depends on dddc_pkg for the counter width and status struct

module dddc_div
	import dddc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CNT_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output div_status_t      status
);

	localparam int STEP_W = $clog2(CNT_W);

	logic             busy_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W:0]   rem_q;
	logic [CNT_W-1:0] quo_q;
	logic [CNT_W-1:0] divisor_q;

	logic [CNT_W:0]   rem_shift;
	logic [CNT_W:0]   rem_diff;
	logic             fits;

	// shift in the next dividend bit and try the subtraction
	assign rem_shift = {rem_q[CNT_W-1:0], quo_q[CNT_W-1]};
	assign rem_diff  = rem_shift - {1'b0, divisor_q};
	assign fits      = (rem_shift >= {1'b0, divisor_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(CNT_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_diff : rem_shift;
			quo_q <= {quo_q[CNT_W-2:0], fits};
		end
	end

	assign status.busy     = busy_q;
	assign status.quotient = quo_q;

endmodule

FILE: bench/door_model_checker.sv
`timescale 1ns / 100ps
// door_model_checker: predicts every result transaction of the door controller and compares it
// with the one the block delivers; depends on dddc_pkg

module door_model_checker
	import dddc_pkg::*;
#(
	parameter int RING_DEPTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  in_item_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  out_item_t             out_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	logic [SAMPLE_W-1:0] rise_level;
	logic [SAMPLE_W-1:0] set_level;
	logic [CNT_W-1:0]    dwell_limit;
	logic [CNT_W-1:0]    bar_step;
	logic [DEB_W-1:0]    debounce_limit;

	logic [SAMPLE_W-1:0] light_ring [RING_DEPTH];
	int unsigned         ring_wr;
	logic [CNT_W-1:0]    bright_ticks;
	logic [CNT_W-1:0]    dark_ticks;
	logic [DOOR_W-1:0]   door_pos;
	logic [DEB_W-1:0]    hold_ticks;
	logic                manual_on;

	out_item_t expected_results [$];
	int        mismatches;

	function automatic void clear_state();
		int k;
		rise_level     = RISE_THRESHOLD_RST;
		set_level      = SET_THRESHOLD_RST;
		dwell_limit    = DWELL_TICKS_RST;
		bar_step       = LED_STEP_RST;
		debounce_limit = DEBOUNCE_TICKS_RST;
		for (k = 0; k < RING_DEPTH; k++) begin
			light_ring[k] = '0;
		end
		ring_wr      = 0;
		bright_ticks = '0;
		dark_ticks   = '0;
		door_pos     = DOOR_UNKNOWN;
		hold_ticks   = '0;
		manual_on    = 1'b0;
		mismatches   = 0;
		expected_results.delete();
	endfunction

	function automatic void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_RISE_THRESHOLD: rise_level = val[SAMPLE_W-1:0];
			CFG_SET_THRESHOLD:  set_level = val[SAMPLE_W-1:0];
			CFG_DWELL_TICKS:    dwell_limit = val[CNT_W-1:0];
			CFG_LED_STEP:       bar_step = val[CNT_W-1:0];
			CFG_DEBOUNCE_TICKS: debounce_limit = val[DEB_W-1:0];
			default: begin
			end
		endcase
	endfunction

	// counts a persisting condition, returns 1 once the dwell limit is held
	function automatic logic dwell_advance(inout logic [CNT_W-1:0] ticks, input logic blocked,
		input logic hit);
		if (blocked || !hit) begin
			ticks = '0;
			return 1'b0;
		end
		if (ticks < dwell_limit) begin
			ticks = ticks + CNT_W'(1);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic out_item_t door_step(in_item_t item);
		out_item_t   res;
		int unsigned sum;
		int unsigned longest;
		int unsigned lit;
		int          k;
		res = '0;
		light_ring[ring_wr] = item.light_sample;
		ring_wr = (ring_wr + 1) % RING_DEPTH;
		sum = 0;
		for (k = 0; k < RING_DEPTH; k++) begin
			sum += 32'(light_ring[k]);
		end
		sum = sum >> AVG_SHIFT;
		if (sum > 32'(SAMPLE_MAX)) begin
			sum = 32'(SAMPLE_MAX);
		end
		res.average_level = sum[SAMPLE_W-1:0];

		// sunrise test has priority, the sunset counter is untouched when it fires
		if (dwell_advance(bright_ticks, door_pos == DOOR_OPEN, res.average_level > rise_level)) begin
			res.open_cmd     = 1'b1;
			res.motor_on_req = 1'b1;
			door_pos         = DOOR_OPEN;
		end else if (dwell_advance(dark_ticks, door_pos == DOOR_CLOSED,
			res.average_level < set_level)) begin
			res.close_cmd    = 1'b1;
			res.motor_on_req = 1'b1;
			door_pos         = DOOR_CLOSED;
		end

		longest = 32'((dark_ticks > bright_ticks) ? dark_ticks : bright_ticks);
		if (bar_step == '0) begin
			res.led_pattern = LED_ALL;
		end else begin
			lit = longest / 32'(bar_step);
			res.led_pattern = (lit >= LED_W) ? LED_ALL : LED_W'((1 << lit) - 1);
		end

		if (item.button_pressed) begin
			if (hold_ticks < debounce_limit) begin
				hold_ticks = hold_ticks + DEB_W'(1);
			end else begin
				res.motor_on_req = 1'b1;
				res.led_pattern  = LED_ALL;
				manual_on        = 1'b1;
				door_pos         = DOOR_UNKNOWN;
			end
		end else begin
			hold_ticks = '0;
			if (manual_on) begin
				manual_on         = 1'b0;
				res.led_pattern   = '0;
				res.motor_off_req = 1'b1;
			end
		end
		res.door_state = door_pos;
		return res;
	endfunction

	function automatic void check_result(out_item_t got);
		out_item_t want;
		if (expected_results.size() == 0) begin
			if (mismatches < 10) begin
				$display("%0t: result transaction with none expected: %h", $time, got);
			end
			mismatches++;
			return;
		end
		want = expected_results.pop_front();
		if (got.open_cmd !== want.open_cmd || got.close_cmd !== want.close_cmd ||
			got.motor_on_req !== want.motor_on_req || got.motor_off_req !== want.motor_off_req ||
			got.door_state !== want.door_state || got.average_level !== want.average_level ||
			got.led_pattern !== want.led_pattern) begin
			if (mismatches < 10) begin
				$display("%0t: mismatch (expected/actual) open %b/%b close %b/%b on %b/%b off %b/%b",
					$time, want.open_cmd, got.open_cmd, want.close_cmd, got.close_cmd,
					want.motor_on_req, got.motor_on_req, want.motor_off_req, got.motor_off_req);
				$display("    door %0d/%0d average %0d/%0d leds %h/%h",
					want.door_state, got.door_state, want.average_level, got.average_level,
					want.led_pattern, got.led_pattern);
			end
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				write_register(cfg_index, cfg_data);
			end
			if (out_valid && !out_stall) begin
				check_result(out_data);
			end
			if (in_valid && !in_stall) begin
				expected_results.push_back(door_step(in_data));
			end
			fail_count <= mismatches;
			pending    <= expected_results.size();
		end
	end

endmodule

FILE: bench/dawn_dusk_door_controller_top_test.sv
`timescale 1ns / 100ps
// dawn_dusk_door_controller_top_test: clock, reset, stimulus and verdict for the door controller
// depends on dddc_pkg, dawn_dusk_door_controller_top and door_model_checker

module dawn_dusk_door_controller_top_test;
	import dddc_pkg::*;

	localparam int RING_DEPTH  = 8;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 100;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	in_item_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int   fail_count;
	int   pending;
	// when low the sender presents transactions back to back
	logic idle_on = 1'b1;

	dawn_dusk_door_controller_top #(
		.RING_DEPTH(RING_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// the checker watches all three channels from outside and reports back a failure count
	door_model_checker #(
		.RING_DEPTH(RING_DEPTH)
	) result_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// sender gap: mostly none, some short, a few long
	function automatic int pick_gap();
		int unsigned roll;
		if (!idle_on) begin
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end
		if (roll < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// presents one transaction and returns at the edge where it is taken; valid stays high so
	// that a following transaction can go out back to back
	task automatic send_item(logic [SAMPLE_W-1:0] light, logic button);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{light_sample: light, button_pressed: button};
		do @(posedge clk); while (in_stall);
	endtask

	// drops valid and waits until every predicted result has been taken
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// rewrites every register while the block is idle; unused upper data bits carry junk, and a
	// stray write to an unused index goes first so a wrap onto index zero is overwritten
	task automatic set_registers(logic [SAMPLE_W-1:0] rise, logic [SAMPLE_W-1:0] set_lvl,
		logic [CNT_W-1:0] dwell, logic [CNT_W-1:0] step, logic [DEB_W-1:0] deb);
		logic [31:0]          junk;
		logic [CFG_IDX_W-1:0] stray;
		wait_idle();
		junk  = $urandom;
		stray = CFG_DEBOUNCE_TICKS + 3'd1 + {1'b0, junk[1:0]};
		write_reg(stray, junk[31:16]);
		write_reg(CFG_RISE_THRESHOLD, {junk[CFG_DATA_W-1:SAMPLE_W], rise});
		write_reg(CFG_SET_THRESHOLD, {junk[31:26], set_lvl});
		write_reg(CFG_DWELL_TICKS, dwell);
		write_reg(CFG_LED_STEP, step);
		write_reg(CFG_DEBOUNCE_TICKS, {junk[23:16], deb});
		cfg_valid <= 1'b0;
	endtask

	task automatic directed_items();
		// reset values: sample extremes, button held too briefly to count
		send_item(SAMPLE_MAX, 1'b0);
		send_item(SAMPLE_MAX, 1'b1);
		send_item('0, 1'b1);
		send_item('0, 1'b0);
		send_item(10'd512, 1'b0);

		// zero rise threshold, top set threshold, zero dwell, led step and debounce: both tests true so sunrise wins,
		// then the door already open clears its counter and sunset fires at once;
		// the button held in a firing tick leaves the position unknown
		set_registers('0, SAMPLE_MAX, '0, '0, '0);
		send_item(SAMPLE_MAX, 1'b0);
		send_item(SAMPLE_MAX, 1'b0);
		send_item('0, 1'b1);
		send_item('0, 1'b1);
		send_item('0, 1'b0);

		// largest dwell: the dark counter climbs past eight lit leds
		set_registers(SAMPLE_MAX, SAMPLE_MAX, 16'hFFFF, 16'd1, 8'hFF);
		repeat (9) send_item('0, 1'b0);

		// dwell lowered below the running count fires on the next dark tick
		set_registers(SAMPLE_MAX, SAMPLE_MAX, 16'd3, 16'hFFFF, 8'hFF);
		send_item('0, 1'b0);
		send_item(SAMPLE_MAX, 1'b1);
	endtask

	// one register setting followed by runs of bright, dark, noisy and button-held ticks
	task automatic random_phase(int phase);
		int unsigned rise, set_lvl, dwell, step, deb;
		int unsigned made, kind, len, lo, hi, k;
		logic        button;
		case (phase)
			0: begin
				// nothing can qualify, only averaging and the button work
				rise = 32'(SAMPLE_MAX); set_lvl = 0; dwell = 1; step = 1; deb = 0;
			end
			1: begin
				rise = $urandom_range(300, 900); set_lvl = $urandom_range(100, rise);
				dwell = 16'hFFFF; step = 16'hFFFF; deb = 8'hFF;
			end
			2: begin
				rise = $urandom_range(300, 900); set_lvl = $urandom_range(100, rise);
				dwell = 1; step = 1; deb = $urandom_range(0, 6);
			end
			default: begin
				rise = $urandom_range(300, 900); set_lvl = $urandom_range(100, rise);
				dwell = $urandom_range(0, 12); step = $urandom_range(0, 4);
				deb = $urandom_range(0, 6);
			end
		endcase
		set_registers(SAMPLE_W'(rise), SAMPLE_W'(set_lvl), CNT_W'(dwell), CNT_W'(step),
			DEB_W'(deb));
		idle_on = ($urandom_range(0, 3) != 0);
		made = 0;

		// longest debounce needs a hold of more than 255 ticks
		if (deb == 8'hFF) begin
			repeat (260) send_item(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), 1'b1);
			send_item(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), 1'b0);
			made = 261;
		end

		while (made < PHASE_ITEMS) begin
			kind = $urandom_range(0, 99);
			len  = $urandom_range(1, ((dwell > 24) ? 24 : dwell) + 6);
			if (kind < 40) begin
				lo = rise; hi = 32'(SAMPLE_MAX);
			end else if (kind < 75) begin
				lo = 0; hi = set_lvl;
			end else begin
				lo = 0; hi = 32'(SAMPLE_MAX);
			end
			if (kind >= 85) begin
				len = $urandom_range(1, ((deb > 20) ? 20 : deb) + 4);
			end
			for (k = 0; k < len; k++) begin
				if (kind >= 85) begin
					button = 1'b1;
				end else if (kind >= 75) begin
					button = 1'($urandom_range(0, 1));
				end else begin
					button = ($urandom_range(0, 19) == 0);
				end
				send_item(SAMPLE_W'($urandom_range(lo, hi)), button);
			end
			made += len;
			// button hold ends in a release
			if (kind >= 85) begin
				send_item(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), 1'b0);
				made++;
			end
		end
	endtask

	// receiver stalls: free stretches, short stalls and now and then a long one
	initial begin : result_stall
		int unsigned pick, busy_len, free_len;
		@(posedge clk);
		forever begin
			pick = $urandom_range(0, 9);
			if (pick < 2) begin
				busy_len = 0;
				free_len = $urandom_range(50, 200);
			end else begin
				busy_len = (pick == 9) ? $urandom_range(10, 40) : $urandom_range(1, 3);
				free_len = $urandom_range(1, 4);
			end
			if (busy_len > 0) begin
				out_stall <= 1'b1;
				repeat (busy_len) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat (free_len) @(posedge clk);
		end
	end

	initial begin : stimulus
		int phase;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_items();
		for (phase = 0; phase < PHASES; phase++) begin
			random_phase(phase);
		end
		wait_idle();
		// let any stray result transaction show up before the verdict
		repeat (30) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// generous limit: several times the slowest correct run
	initial begin : watchdog
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
